FILE: design/i2c_bus_clear_sequencer_core_assert.svh
// Assertion macros for the I2C bus clear sequencer core.
`ifndef I2C_BUS_CLEAR_SEQUENCER_CORE_ASSERT_SVH
`define I2C_BUS_CLEAR_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cbc assertion failed");
`define I2CBC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("i2cbc assertion failed");
`else
`define I2CBC_ASSERT(lbl, prop)
`define I2CBC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/i2cbc_pkg.sv
// Types and constants shared by the I2C bus clear sequencer modules.
`timescale 1ns / 1ps
package i2cbc_pkg;

    localparam int HalfWidth   = 16;
    localparam int TickWidth   = 20;
    localparam int CountWidth  = 8;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDatWidth = 32;

    localparam logic [HalfWidth-1:0]  HALF_PERIOD_RESET = 16'd10;
    localparam logic [TickWidth-1:0]  POLL_TICKS_RESET  = 20'd100000;
    localparam logic [CountWidth-1:0] STRETCH_RESET     = 8'd20;
    localparam logic [CountWidth-1:0] MAX_PULSES_RESET  = 8'd20;

    localparam logic [CfgIdxWidth-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_POLL_TICKS    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_STRETCH_POLLS = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_MAX_PULSES    = 2'd3;

    localparam logic [1:0] ST_CLEARED   = 2'd0;
    localparam logic [1:0] ST_SCL_LOW   = 2'd1;
    localparam logic [1:0] ST_STRETCH   = 2'd2;
    localparam logic [1:0] ST_SDA_STUCK = 2'd3;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SCL_LOW = 6'b000010,
        PH_SCL_REL = 6'b000100,
        PH_STRETCH = 6'b001000,
        PH_SDA_LOW = 6'b010000,
        PH_SDA_REL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic op;
        logic scl_level;
        logic sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [HalfWidth-1:0]  half_period_ticks;
        logic [TickWidth-1:0]  poll_ticks;
        logic [CountWidth-1:0] stretch_polls;
        logic [CountWidth-1:0] max_pulses;
    } cfg_t;

endpackage

FILE: design/i2c_bus_clear_sequencer_core.sv
// Top level of the I2C bus clear sequencer: input register, sequencer, result register.
//
//   channel   direction  handshake               payload
//   in        in         in_valid / in_ready     in_data   (op, scl_level, sda_level)
//   out       out        out_valid / out_ready   out_data  (drives, busy, done, status)
//   cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; an item's result reaches out through
// the input register, then the result register.
// The sequencer state advances once per item as it moves into the result register.
// Reset clears the sequencer to idle and loads the default configuration.
// A stalled out channel holds the result register, then the input register, then in_ready.
// cfg_ready is always high; a write takes effect on the next cycle.
`timescale 1ns / 1ps
`include "i2c_bus_clear_sequencer_core_assert.svh"
module i2c_bus_clear_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  i2cbc_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output i2cbc_pkg::out_item_t                out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cbc_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [i2cbc_pkg::CfgDatWidth-1:0]   cfg_data
);

    logic                  in_valid_reg;
    i2cbc_pkg::in_item_t   in_item_reg;
    logic                  out_valid_reg;
    i2cbc_pkg::out_item_t  out_item_reg;
    logic                  advance;
    i2cbc_pkg::cfg_t       cfg;
    i2cbc_pkg::out_item_t  result;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    i2cbc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    i2cbc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `I2CBC_ASSERT(a_done_not_busy, out_valid |-> !(out_data.done_res && out_data.busy_res))
    `I2CBC_ASSERT(a_drive_needs_busy,
        out_valid && (out_data.scl_drive_low || out_data.sda_drive_low) |-> out_data.busy_res)
    `I2CBC_ASSERT(a_one_drive, out_valid |-> !(out_data.scl_drive_low && out_data.sda_drive_low))
    `I2CBC_ASSERT(a_ready_when_empty, !out_valid_reg |-> in_ready)
    `I2CBC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid && in_ready)

endmodule

FILE: design/i2cbc_cfg.sv
// Configuration register file of the I2C bus clear sequencer.
`timescale 1ns / 1ps
module i2cbc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [i2cbc_pkg::CfgIdxWidth-1:0]   wr_index,
    input  logic [i2cbc_pkg::CfgDatWidth-1:0]   wr_data,
    output i2cbc_pkg::cfg_t                     cfg
);

    i2cbc_pkg::cfg_t cfg_reg;
    i2cbc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                i2cbc_pkg::CFG_HALF_PERIOD:
                    cfg_next.half_period_ticks = wr_data[i2cbc_pkg::HalfWidth-1:0];
                i2cbc_pkg::CFG_POLL_TICKS:
                    cfg_next.poll_ticks = wr_data[i2cbc_pkg::TickWidth-1:0];
                i2cbc_pkg::CFG_STRETCH_POLLS:
                    cfg_next.stretch_polls = wr_data[i2cbc_pkg::CountWidth-1:0];
                i2cbc_pkg::CFG_MAX_PULSES:
                    cfg_next.max_pulses = wr_data[i2cbc_pkg::CountWidth-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= i2cbc_pkg::HALF_PERIOD_RESET;
            cfg_reg.poll_ticks        <= i2cbc_pkg::POLL_TICKS_RESET;
            cfg_reg.stretch_polls     <= i2cbc_pkg::STRETCH_RESET;
            cfg_reg.max_pulses        <= i2cbc_pkg::MAX_PULSES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/i2cbc_seq.sv
// Recovery state machine: sequencer state and the per-item step logic.
`timescale 1ns / 1ps
module i2cbc_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  i2cbc_pkg::in_item_t   item,
    input  i2cbc_pkg::cfg_t       cfg,
    output i2cbc_pkg::out_item_t  result
);

    localparam int TW = i2cbc_pkg::TickWidth;
    localparam int CW = i2cbc_pkg::CountWidth;

    i2cbc_pkg::phase_t phase_reg,  phase_next;
    logic [TW-1:0]     tick_reg,   tick_next;
    logic [CW-1:0]     pulses_reg, pulses_next;
    logic [CW-1:0]     polls_reg,  polls_next;
    logic [1:0]        status_reg, status_next;
    logic              done;

    logic [TW-1:0]     half_len;
    logic              half_exp;
    logic              poll_exp;
    logic [TW-1:0]     tick_inc;
    logic [CW-1:0]     polls_dec;

    logic [CW-1:0]     chk_base;
    i2cbc_pkg::phase_t chk_phase;
    logic [TW-1:0]     chk_tick;
    logic [CW-1:0]     chk_pulses;
    logic              chk_done;

    assign half_len  = {{(TW-i2cbc_pkg::HalfWidth){1'b0}}, cfg.half_period_ticks};
    assign half_exp  = (tick_reg >= half_len);
    assign poll_exp  = (tick_reg >= cfg.poll_ticks);
    assign tick_inc  = tick_reg + {{(TW-1){1'b0}}, 1'b1};
    assign polls_dec = polls_reg - {{(CW-1){1'b0}}, 1'b1};

    // Decide on SDA with SCL known high: start/stop, pulse again, or give up.
    always_comb
    begin
        chk_base   = (phase_reg == i2cbc_pkg::PH_IDLE) ? cfg.max_pulses : pulses_reg;
        chk_pulses = chk_base;
        chk_done   = 1'b0;
        chk_tick   = {{(TW-1){1'b0}}, 1'b1};
        if (item.sda_level)
        begin
            chk_phase = i2cbc_pkg::PH_SDA_LOW;
        end
        else if (chk_base == '0)
        begin
            chk_phase = i2cbc_pkg::PH_IDLE;
            chk_tick  = '0;
            chk_done  = 1'b1;
        end
        else
        begin
            chk_phase  = i2cbc_pkg::PH_SCL_LOW;
            chk_pulses = chk_base - {{(CW-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        pulses_next = pulses_reg;
        polls_next  = polls_reg;
        status_next = status_reg;
        done        = 1'b0;
        case (phase_reg)
            i2cbc_pkg::PH_IDLE:
            begin
                if (item.op)
                begin
                    if (!item.scl_level)
                    begin
                        pulses_next = cfg.max_pulses;
                        tick_next   = '0;
                        status_next = i2cbc_pkg::ST_SCL_LOW;
                        done        = 1'b1;
                    end
                    else
                    begin
                        phase_next  = chk_phase;
                        tick_next   = chk_tick;
                        pulses_next = chk_pulses;
                        if (chk_done)
                        begin
                            status_next = i2cbc_pkg::ST_SDA_STUCK;
                            done        = 1'b1;
                        end
                    end
                end
            end
            i2cbc_pkg::PH_SCL_LOW:
            begin
                if (half_exp)
                begin
                    phase_next = i2cbc_pkg::PH_SCL_REL;
                    tick_next  = {{(TW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            i2cbc_pkg::PH_SCL_REL:
            begin
                if (!half_exp)
                begin
                    tick_next = tick_inc;
                end
                else if (item.scl_level)
                begin
                    phase_next  = chk_phase;
                    tick_next   = chk_tick;
                    pulses_next = chk_pulses;
                    if (chk_done)
                    begin
                        status_next = i2cbc_pkg::ST_SDA_STUCK;
                        done        = 1'b1;
                    end
                end
                else if (cfg.stretch_polls == '0)
                begin
                    phase_next  = i2cbc_pkg::PH_IDLE;
                    tick_next   = '0;
                    status_next = i2cbc_pkg::ST_STRETCH;
                    done        = 1'b1;
                end
                else
                begin
                    polls_next = cfg.stretch_polls;
                    phase_next = i2cbc_pkg::PH_STRETCH;
                    tick_next  = {{(TW-1){1'b0}}, 1'b1};
                end
            end
            i2cbc_pkg::PH_STRETCH:
            begin
                if (!poll_exp)
                begin
                    tick_next = tick_inc;
                end
                else
                begin
                    polls_next = polls_dec;
                    if (item.scl_level)
                    begin
                        phase_next  = chk_phase;
                        tick_next   = chk_tick;
                        pulses_next = chk_pulses;
                        if (chk_done)
                        begin
                            status_next = i2cbc_pkg::ST_SDA_STUCK;
                            done        = 1'b1;
                        end
                    end
                    else if (polls_dec == '0)
                    begin
                        phase_next  = i2cbc_pkg::PH_IDLE;
                        tick_next   = '0;
                        status_next = i2cbc_pkg::ST_STRETCH;
                        done        = 1'b1;
                    end
                    else
                    begin
                        tick_next = {{(TW-1){1'b0}}, 1'b1};
                    end
                end
            end
            i2cbc_pkg::PH_SDA_LOW:
            begin
                if (half_exp)
                begin
                    phase_next = i2cbc_pkg::PH_SDA_REL;
                    tick_next  = {{(TW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            i2cbc_pkg::PH_SDA_REL:
            begin
                if (half_exp)
                begin
                    phase_next  = i2cbc_pkg::PH_IDLE;
                    tick_next   = '0;
                    status_next = i2cbc_pkg::ST_CLEARED;
                    done        = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                phase_next = i2cbc_pkg::PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= i2cbc_pkg::PH_IDLE;
            tick_reg   <= '0;
            pulses_reg <= '0;
            polls_reg  <= '0;
            status_reg <= i2cbc_pkg::ST_CLEARED;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            pulses_reg <= pulses_next;
            polls_reg  <= polls_next;
            status_reg <= status_next;
        end
    end

    assign result.scl_drive_low = (phase_next == i2cbc_pkg::PH_SCL_LOW);
    assign result.sda_drive_low = (phase_next == i2cbc_pkg::PH_SDA_LOW);
    assign result.busy_res      = (phase_next != i2cbc_pkg::PH_IDLE);
    assign result.done_res      = done;
    assign result.status        = status_next;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the I2C bus clear sequencer core: directed table, then random items.
`timescale 1ns / 1ps
module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;

    typedef enum logic [1:0] {
        FLOW_STEADY,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_mode_e;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e                              kind;
        i2cbc_pkg::in_item_t                    stim;
        logic                                   typed;
        i2cbc_pkg::out_item_t                   want;
        logic [i2cbc_pkg::CfgIdxWidth-1:0]      idx;
        logic [i2cbc_pkg::CfgDatWidth-1:0]      value;
    } directed_row_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b1;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    i2cbc_pkg::in_item_t                    in_data = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    i2cbc_pkg::out_item_t                   out_data;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [i2cbc_pkg::CfgIdxWidth-1:0]      cfg_index = '0;
    logic [i2cbc_pkg::CfgDatWidth-1:0]      cfg_data = '0;

    i2cbc_pkg::cfg_t                        bus_cfg;
    i2cbc_pkg::phase_t                      rec_phase;
    logic [i2cbc_pkg::TickWidth-1:0]        rec_ticks;
    logic [i2cbc_pkg::CountWidth-1:0]       rec_pulses;
    logic [i2cbc_pkg::CountWidth-1:0]       rec_polls;
    logic [1:0]                             rec_status;
    logic                                   rec_done;

    i2cbc_pkg::out_item_t                   pending_results[$];
    directed_row_t                          directed_rows[$];
    int                                     mismatches = 0;
    int                                     results_seen = 0;
    int                                     quiet_cycles = 0;
    int                                     send_gap_pct = 0;
    int                                     recv_stall_pct = 0;
    int                                     scl_low_pct = 5;
    int                                     sda_low_pct = 50;

    i2c_bus_clear_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t ns: result %0d: %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
        end
    endtask

    task automatic finish_seq(input logic [1:0] code);
        rec_phase  = i2cbc_pkg::PH_IDLE;
        rec_ticks  = '0;
        rec_status = code;
        rec_done   = 1'b1;
    endtask

    task automatic enter_phase(input i2cbc_pkg::phase_t next);
        rec_phase = next;
        rec_ticks = {{(i2cbc_pkg::TickWidth-1){1'b0}}, 1'b1};
    endtask

    task automatic decide_on_sda(input logic sda);
        if (sda)
        begin
            enter_phase(i2cbc_pkg::PH_SDA_LOW);
        end
        else if (rec_pulses == 0)
        begin
            finish_seq(i2cbc_pkg::ST_SDA_STUCK);
        end
        else
        begin
            rec_pulses = rec_pulses - 1'b1;
            enter_phase(i2cbc_pkg::PH_SCL_LOW);
        end
    endtask

    function automatic logic phase_elapsed(input logic [i2cbc_pkg::TickWidth-1:0] span);
        if (rec_ticks >= span)
            return 1'b1;
        rec_ticks = rec_ticks + 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_result(input i2cbc_pkg::in_item_t it,
                                  output i2cbc_pkg::out_item_t res);
        logic [i2cbc_pkg::TickWidth-1:0] half;
        half = {{(i2cbc_pkg::TickWidth-i2cbc_pkg::HalfWidth){1'b0}},
                bus_cfg.half_period_ticks};
        rec_done = 1'b0;
        case (rec_phase)
            i2cbc_pkg::PH_IDLE:
            begin
                if (it.op)
                begin
                    rec_pulses = bus_cfg.max_pulses;
                    if (!it.scl_level)
                        finish_seq(i2cbc_pkg::ST_SCL_LOW);
                    else
                        decide_on_sda(it.sda_level);
                end
            end
            i2cbc_pkg::PH_SCL_LOW:
            begin
                if (phase_elapsed(half))
                    enter_phase(i2cbc_pkg::PH_SCL_REL);
            end
            i2cbc_pkg::PH_SCL_REL:
            begin
                if (phase_elapsed(half))
                begin
                    if (it.scl_level)
                    begin
                        decide_on_sda(it.sda_level);
                    end
                    else if (bus_cfg.stretch_polls == 0)
                    begin
                        finish_seq(i2cbc_pkg::ST_STRETCH);
                    end
                    else
                    begin
                        rec_polls = bus_cfg.stretch_polls;
                        enter_phase(i2cbc_pkg::PH_STRETCH);
                    end
                end
            end
            i2cbc_pkg::PH_STRETCH:
            begin
                if (phase_elapsed(bus_cfg.poll_ticks))
                begin
                    rec_polls = rec_polls - 1'b1;
                    if (it.scl_level)
                        decide_on_sda(it.sda_level);
                    else if (rec_polls == 0)
                        finish_seq(i2cbc_pkg::ST_STRETCH);
                    else
                        rec_ticks = {{(i2cbc_pkg::TickWidth-1){1'b0}}, 1'b1};
                end
            end
            i2cbc_pkg::PH_SDA_LOW:
            begin
                if (phase_elapsed(half))
                    enter_phase(i2cbc_pkg::PH_SDA_REL);
            end
            i2cbc_pkg::PH_SDA_REL:
            begin
                if (phase_elapsed(half))
                    finish_seq(i2cbc_pkg::ST_CLEARED);
            end
            default:
            begin
                rec_phase = i2cbc_pkg::PH_IDLE;
                rec_ticks = '0;
            end
        endcase
        res.scl_drive_low = (rec_phase == i2cbc_pkg::PH_SCL_LOW);
        res.sda_drive_low = (rec_phase == i2cbc_pkg::PH_SDA_LOW);
        res.busy_res      = (rec_phase != i2cbc_pkg::PH_IDLE);
        res.done_res      = rec_done;
        res.status        = rec_status;
    endtask

    task automatic set_flow(input flow_mode_e mode);
        send_gap_pct   = (mode == FLOW_SEND_GAPS) ? 71 : (mode == FLOW_BOTH) ? 33 : 0;
        recv_stall_pct = (mode == FLOW_RECV_STALLS) ? 71 : (mode == FLOW_BOTH) ? 33 : 0;
    endtask

    task automatic send_item(input i2cbc_pkg::in_item_t it, input logic typed,
                             input i2cbc_pkg::out_item_t want);
        i2cbc_pkg::out_item_t model_res;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_result(it, model_res);
        pending_results.push_back(typed ? want : model_res);
    endtask

    task automatic write_reg(input logic [i2cbc_pkg::CfgIdxWidth-1:0] idx,
                             input logic [i2cbc_pkg::CfgDatWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            i2cbc_pkg::CFG_HALF_PERIOD:
                bus_cfg.half_period_ticks = value[i2cbc_pkg::HalfWidth-1:0];
            i2cbc_pkg::CFG_POLL_TICKS:
                bus_cfg.poll_ticks        = value[i2cbc_pkg::TickWidth-1:0];
            i2cbc_pkg::CFG_STRETCH_POLLS:
                bus_cfg.stretch_polls     = value[i2cbc_pkg::CountWidth-1:0];
            i2cbc_pkg::CFG_MAX_PULSES:
                bus_cfg.max_pulses        = value[i2cbc_pkg::CountWidth-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle_bus();
        while (rec_phase != i2cbc_pkg::PH_IDLE)
            send_item(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b1}, 1'b0, '0);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pick_random_item(output i2cbc_pkg::in_item_t it);
        if (rec_phase == i2cbc_pkg::PH_IDLE)
        begin
            case ($urandom_range(2))
                0: scl_low_pct = 3;
                1: scl_low_pct = 25;
                default: scl_low_pct = 60;
            endcase
            case ($urandom_range(2))
                0: sda_low_pct = 10;
                1: sda_low_pct = 50;
                default: sda_low_pct = 85;
            endcase
        end
        if ($urandom_range(99) < 10)
        begin
            it = i2cbc_pkg::in_item_t'(3'($urandom_range(7)));
        end
        else
        begin
            it.op        = ($urandom_range(99) < ((rec_phase == i2cbc_pkg::PH_IDLE) ? 50 : 10));
            it.scl_level = ($urandom_range(99) >= scl_low_pct);
            it.sda_level = ($urandom_range(99) >= sda_low_pct);
        end
    endtask

    function automatic void add_item(input i2cbc_pkg::in_item_t stim);
        directed_rows.push_back('{ROW_ITEM, stim, 1'b0, '0, '0, '0});
    endfunction

    function automatic void add_checked(input i2cbc_pkg::in_item_t stim,
                                        input i2cbc_pkg::out_item_t want);
        directed_rows.push_back('{ROW_ITEM, stim, 1'b1, want, '0, '0});
    endfunction

    function automatic void add_cfg(input logic [i2cbc_pkg::CfgIdxWidth-1:0] idx,
                                    input logic [i2cbc_pkg::CfgDatWidth-1:0] value);
        directed_rows.push_back('{ROW_CFG, '0, 1'b0, '0, idx, value});
    endfunction

    task automatic check_result(input i2cbc_pkg::out_item_t got);
        i2cbc_pkg::out_item_t want;
        if (pending_results.size() == 0)
        begin
            flag_mismatch("result with no item pending", int'(got), 0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.scl_drive_low !== want.scl_drive_low)
                flag_mismatch("scl_drive_low", int'(got.scl_drive_low),
                              int'(want.scl_drive_low));
            if (got.sda_drive_low !== want.sda_drive_low)
                flag_mismatch("sda_drive_low", int'(got.sda_drive_low),
                              int'(want.sda_drive_low));
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            if (got.status !== want.status)
                flag_mismatch("status", int'(got.status), int'(want.status));
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** i2c_bus_clear_sequencer_core: FAILED **");
                $finish;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        i2cbc_pkg::in_item_t it;
        rst_n <= 1'b0;
        bus_cfg.half_period_ticks = i2cbc_pkg::HALF_PERIOD_RESET;
        bus_cfg.poll_ticks        = i2cbc_pkg::POLL_TICKS_RESET;
        bus_cfg.stretch_polls     = i2cbc_pkg::STRETCH_RESET;
        bus_cfg.max_pulses        = i2cbc_pkg::MAX_PULSES_RESET;
        rec_phase  = i2cbc_pkg::PH_IDLE;
        rec_ticks  = '0;
        rec_pulses = '0;
        rec_polls  = '0;
        rec_status = i2cbc_pkg::ST_CLEARED;
        rec_done   = 1'b0;

        add_checked(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b0, i2cbc_pkg::ST_CLEARED});
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b0, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_SCL_LOW});
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b0},
                    i2cbc_pkg::out_item_t'{1'b1, 1'b0, 1'b1, 1'b0, i2cbc_pkg::ST_SCL_LOW});
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b1, 1'b0, 1'b1, 1'b0, i2cbc_pkg::ST_SCL_LOW});

        add_cfg(i2cbc_pkg::CFG_HALF_PERIOD, 0);
        add_cfg(i2cbc_pkg::CFG_POLL_TICKS, 0);
        add_cfg(i2cbc_pkg::CFG_STRETCH_POLLS, 0);
        add_cfg(i2cbc_pkg::CFG_MAX_PULSES, 0);
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b0},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_SDA_STUCK});
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b1, 1'b1, 1'b0, i2cbc_pkg::ST_SDA_STUCK});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b1});
        add_checked(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_CLEARED});

        add_cfg(i2cbc_pkg::CFG_MAX_PULSES, 1);
        add_item(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b0});
        add_checked(i2cbc_pkg::in_item_t'{1'b0, 1'b0, 1'b0},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_STRETCH});

        add_cfg(i2cbc_pkg::CFG_STRETCH_POLLS, 2);
        add_item(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b0, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b0, 1'b0});
        add_checked(i2cbc_pkg::in_item_t'{1'b0, 1'b0, 1'b0},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_STRETCH});
        add_item(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b0});
        add_item(i2cbc_pkg::in_item_t'{1'b0, 1'b0, 1'b0});
        add_checked(i2cbc_pkg::in_item_t'{1'b0, 1'b1, 1'b0},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, i2cbc_pkg::ST_SDA_STUCK});

        add_cfg(i2cbc_pkg::CFG_HALF_PERIOD, 32'hFFFF_0001);
        add_cfg(i2cbc_pkg::CFG_POLL_TICKS, 32'hFFFF_FFFF);
        add_cfg(i2cbc_pkg::CFG_STRETCH_POLLS, 32'hFFFF_FFFF);
        add_cfg(i2cbc_pkg::CFG_MAX_PULSES, 32'hFFFF_FFFF);
        add_checked(i2cbc_pkg::in_item_t'{1'b1, 1'b1, 1'b1},
                    i2cbc_pkg::out_item_t'{1'b0, 1'b1, 1'b1, 1'b0, i2cbc_pkg::ST_SDA_STUCK});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_flow(FLOW_STEADY);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_bus();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end
            else
            begin
                send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_bus();
            write_reg(i2cbc_pkg::CFG_HALF_PERIOD,
                      ($urandom << i2cbc_pkg::HalfWidth) | $urandom_range(3));
            write_reg(i2cbc_pkg::CFG_POLL_TICKS,
                      ($urandom << i2cbc_pkg::TickWidth) | $urandom_range(3));
            write_reg(i2cbc_pkg::CFG_STRETCH_POLLS,
                      ($urandom << i2cbc_pkg::CountWidth) | $urandom_range(4));
            write_reg(i2cbc_pkg::CFG_MAX_PULSES,
                      ($urandom << i2cbc_pkg::CountWidth) | $urandom_range(5));
            set_flow(flow_mode_e'(p % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick_random_item(it);
                send_item(it, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** i2c_bus_clear_sequencer_core: PASSED **");
        else
            $display("** i2c_bus_clear_sequencer_core: FAILED **");
        $finish;
    end

endmodule
